// File: hdl/hsha_pkg.sv
package hsha_pkg;

	localparam int KEY_REGS = 8;
	localparam int KEY_W = 64;
	localparam int CFG_IDX_W = 3;
	localparam int DIGEST_WORDS = 5;

	localparam logic [31:0] IPAD_WORD = 32'h36363636;
	localparam logic [31:0] OPAD_WORD = 32'h5c5c5c5c;
	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [31:0] OUTER_LEN_BITS = 32'd672;

	localparam logic [31:0] SHA_IV [5] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
	};

	function automatic logic [31:0] round_k(input logic [6:0] t);
		if (t < 7'd20) return 32'h5a827999;
		else if (t < 7'd40) return 32'h6ed9eba1;
		else if (t < 7'd60) return 32'h8f1bbcdc;
		else return 32'hca62c1d6;
	endfunction

	function automatic logic [31:0] round_f(input logic [6:0] t,
			input logic [31:0] b, input logic [31:0] c, input logic [31:0] d);
		if (t < 7'd20) return d ^ (b & (c ^ d));
		else if (t < 7'd40 || t >= 7'd60) return b ^ c ^ d;
		else return (b & c) | (b & d) | (c & d);
	endfunction

	// Control from the sequencer to the round core.
	typedef struct packed {
		logic start;  // load working variables from the chain value
		logic iv;     // chain value back to the initial values
	} core_ctl_t;

endpackage

// File: hdl/hsha_core.sv
// SHA-1 compression core: one round per cycle, schedule kept in a 16-word
// sliding window. The window is loaded by the sequencer before start.
module hsha_core
	import hsha_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  core_ctl_t   ctl,
	input  logic        win_we,
	input  logic [3:0]  win_addr,
	input  logic [31:0] win_data,
	output logic        busy,
	output logic        done,
	output logic [31:0] chain [5]
);

	logic [31:0] w_q [16];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [31:0] h_q [5];
	logic [6:0]  t_q;
	logic        busy_q, done_q;
	logic [31:0] wt, wnew, tmp;

	assign wnew = {w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0]};
	assign wt = (t_q < 7'd16) ? w_q[0] : {wnew[30:0], wnew[31]};
	assign tmp = {a_q[26:0], a_q[31:27]} + round_f(t_q, b_q, c_q, d_q) + e_q + wt
		+ round_k(t_q);

	always_ff @(posedge clk) begin
		if (busy_q) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wt;
		end else if (win_we) begin
			w_q[win_addr] <= win_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			t_q <= '0;
			for (int i = 0; i < 5; i++) h_q[i] <= SHA_IV[i];
			{a_q, b_q, c_q, d_q, e_q} <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.iv) begin
				for (int i = 0; i < 5; i++) h_q[i] <= SHA_IV[i];
			end
			if (ctl.start) begin
				busy_q <= 1'b1;
				t_q <= '0;
				a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2];
				d_q <= h_q[3]; e_q <= h_q[4];
			end else if (busy_q) begin
				a_q <= tmp; b_q <= a_q; c_q <= {b_q[1:0], b_q[31:2]};
				d_q <= c_q; e_q <= d_q;
				t_q <= t_q + 7'd1;
				if (t_q == 7'd79) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					h_q[0] <= h_q[0] + tmp;
					h_q[1] <= h_q[1] + a_q;
					h_q[2] <= h_q[2] + {b_q[1:0], b_q[31:2]};
					h_q[3] <= h_q[3] + c_q;
					h_q[4] <= h_q[4] + d_q;
				end
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign chain = h_q;

	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !ctl.start) else $error("start while busy");
	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && t_q == 7'd79 && !ctl.start) |=> done_q) else $error("missed done");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> t_q < 7'd80) else $error("round count range");

endmodule

// File: hdl/hmac_sha1_engine_top.sv
// HMAC-SHA1 engine over a byte stream.
// Input channel: in_valid/in_stall carry one beat per message byte with
// data_byte, byte_present and last_byte. byte_present low lets a beat carry
// no byte (for example an empty final beat). The first beat of each message
// first hashes the key XOR 0x36 block. A plain beat goes through accept,
// byte write and bookkeeping. The beat that fills a 64-byte block also
// waits while the shared round core runs 80 rounds, one per cycle.
// in_stall stays high while the engine works.
// On a beat with last_byte high, the engine pads the inner hash (one or two
// blocks, with the 64-bit bit length), then hashes key XOR 0x5c and the inner
// digest. Then it sends five beats on the output channel (out_valid,
// out_stall): digest_word, word_index 0..4, last_word on the fifth.
// A stalled output holds the word; the engine waits until all five are taken
// before accepting the next beat. Key registers are written through cfg_we,
// cfg_index, cfg_data; the user must write them only while idle, which the
// block itself does not enforce. cfg_index reaches all eight registers, 0..7.
// Reset (arst_n low) clears the key to zero and returns to the idle state.
module hmac_sha1_engine_top
	import hsha_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [KEY_W-1:0]     cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_KEYLD  = 9'b000000010,  // load a pad block into the window
		S_RUN    = 9'b000000100,  // wait for the core
		S_BYTE   = 9'b000001000,  // after a beat: start padding or return to idle
		S_PAD    = 9'b000010000,  // padding bytes
		S_OUTLD  = 9'b000100000,  // outer second block load
		S_EMIT   = 9'b001000000,
		S_WRBYTE = 9'b010000000,  // the accepted byte
		S_START  = 9'b100000000
	} state_t;

	// What to do when the core finishes.
	typedef enum logic [2:0] {
		N_IN = 3'b001, N_PAD = 3'b010, N_OUT = 3'b100
	} next_t;

	state_t state_q;
	next_t  after_q;
	logic [KEY_W-1:0] key_q [KEY_REGS];
	logic [5:0]  pos_q;
	logic [63:0] len_q;
	logic [63:0] fin_len_q;
	logic [7:0]  byte_q;
	logic        last_q, keyed_q, outer_q, opad_q;
	logic [3:0]  ld_q;
	logic [3:0]  pad_cnt_q;   // padding progress (0 before 0x80, 14 last inner block, 15 outer)
	logic        len_phase_q;
	logic [31:0] inner_q [5];
	logic [31:0] win_word_q;
	logic [2:0]  emit_q;

	core_ctl_t   ctl;
	logic        win_we;
	logic [3:0]  win_addr;
	logic [31:0] win_data;
	logic        core_busy, core_done;
	logic [31:0] chain [5];

	hsha_core u_core (
		.clk, .arst_n, .ctl, .win_we, .win_addr, .win_data,
		.busy(core_busy), .done(core_done), .chain
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KEY_REGS; i++) key_q[i] <= '0;
		end else if (cfg_we) begin
			key_q[cfg_index] <= cfg_data;
		end
	end

	logic [63:0] kreg;
	logic [31:0] kword, pad_word;
	logic [7:0]  cur_byte;
	logic [4:0]  sh;
	assign kreg = key_q[ld_q[3:1]];
	assign pad_word = opad_q ? OPAD_WORD : IPAD_WORD;
	assign kword = (ld_q[0] ? kreg[31:0] : kreg[63:32]) ^ pad_word;
	assign sh = {~pos_q[1:0], 3'b000};

	// Byte to place: accepted byte, 0x80, zero fill or a length byte.
	always_comb begin
		case (state_q)
			S_WRBYTE: cur_byte = byte_q;
			S_PAD: begin
				if (len_phase_q) cur_byte = fin_len_q[63:56];
				else if (pad_cnt_q == 4'd0) cur_byte = PAD_BYTE;
				else cur_byte = 8'h00;
			end
			default: cur_byte = 8'h00;
		endcase
	end

	// Read-modify-write of a window word is avoided by assembling whole
	// words in win_word_q and writing the word when its last byte lands.
	logic [31:0] merged;
	assign merged = win_word_q | ({24'd0, cur_byte} << sh);

	logic [31:0] outer_word;
	always_comb begin
		case (ld_q)
			4'd0, 4'd1, 4'd2, 4'd3, 4'd4: outer_word = inner_q[ld_q[2:0]];
			4'd5: outer_word = 32'h80000000;
			4'd15: outer_word = OUTER_LEN_BITS;
			default: outer_word = 32'd0;
		endcase
	end

	always_comb begin
		win_we = 1'b0;
		win_addr = ld_q;
		win_data = kword;
		case (state_q)
			S_KEYLD: win_we = 1'b1;
			S_OUTLD: begin win_we = 1'b1; win_data = outer_word; end
			S_WRBYTE, S_PAD: begin
				win_we = (pos_q[1:0] == 2'd3);
				win_addr = pos_q[5:2];
				win_data = merged;
			end
			default: ;
		endcase
	end

	logic byte_go;
	assign byte_go = (state_q == S_WRBYTE) || (state_q == S_PAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			after_q <= N_IN;
			pos_q <= '0; len_q <= '0; keyed_q <= 1'b0; outer_q <= 1'b0;
			opad_q <= 1'b0; ld_q <= '0; pad_cnt_q <= '0; len_phase_q <= 1'b0;
			emit_q <= '0; win_word_q <= '0; last_q <= 1'b0; byte_q <= '0;
			fin_len_q <= '0;
			for (int i = 0; i < 5; i++) inner_q[i] <= '0;
		end else begin
			if (byte_go) begin
				win_word_q <= (pos_q[1:0] == 2'd3) ? 32'd0 : merged;
				pos_q <= pos_q + 6'd1;
				if (len_phase_q) fin_len_q <= {fin_len_q[55:0], 8'd0};
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						byte_q <= data_byte;
						last_q <= last_byte;
						// The key block counts as the first 512 bits of the inner hash.
						if (!keyed_q) len_q <= 64'd512 + (byte_present ? 64'd8 : 64'd0);
						else if (byte_present) len_q <= len_q + 64'd8;
						if (!keyed_q) begin
							state_q <= S_KEYLD;
							ld_q <= '0; opad_q <= 1'b0;
							after_q <= N_IN;
						end else begin
							state_q <= byte_present ? S_WRBYTE : S_BYTE;
						end
						keyed_q <= 1'b1;
						outer_q <= ~byte_present; // reuse: no byte flag
					end
				end
				S_KEYLD, S_OUTLD: begin
					ld_q <= ld_q + 4'd1;
					if (ld_q == 4'd15) state_q <= S_START;
				end
				S_START: state_q <= S_RUN;
				S_RUN: begin
					if (core_done) begin
						case (after_q)
							N_IN: state_q <= outer_q ? S_BYTE : S_WRBYTE;
							N_PAD: state_q <= (pad_cnt_q == 4'd15) ? S_EMIT : S_PAD;
							N_OUT: begin
								// outer key block done; load inner digest block
								state_q <= S_OUTLD; ld_q <= '0;
								pad_cnt_q <= 4'd15;
								after_q <= N_PAD;
							end
							default: state_q <= S_IDLE;
						endcase
						if (after_q == N_PAD && pad_cnt_q == 4'd15) emit_q <= '0;
					end
				end
				S_WRBYTE: begin
					outer_q <= 1'b1;  // byte consumed
					if (pos_q == 6'd63) begin
						state_q <= S_START; after_q <= N_IN;
					end else begin
						state_q <= S_BYTE;
					end
				end
				S_BYTE: begin
					if (last_q) begin
						state_q <= S_PAD; pad_cnt_q <= '0; len_phase_q <= 1'b0;
						fin_len_q <= len_q;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_PAD: begin
					if (!len_phase_q) begin
						if (pad_cnt_q == 4'd0) pad_cnt_q <= 4'd1;
						if (pos_q == 6'd55) begin
							len_phase_q <= 1'b1; pad_cnt_q <= 4'd1;
						end
						if (pos_q == 6'd63) begin
							state_q <= S_START; after_q <= N_PAD;
						end
					end else if (pos_q == 6'd63) begin
						// inner hash complete after this block
						state_q <= S_START; after_q <= N_PAD;
						len_phase_q <= 1'b0;
						pad_cnt_q <= 4'd14;
					end
				end
				default: ;
			endcase
			// After the final inner block: capture digest, start outer pass.
			if (state_q == S_RUN && core_done && after_q == N_PAD
					&& pad_cnt_q == 4'd14) begin
				for (int i = 0; i < 5; i++) inner_q[i] <= chain[i];
				state_q <= S_KEYLD; ld_q <= '0; opad_q <= 1'b1;
				after_q <= N_OUT;
			end
			if (state_q == S_EMIT && !out_stall) begin
				emit_q <= emit_q + 3'd1;
				if (emit_q == 3'd4) begin
					state_q <= S_IDLE;
					len_q <= '0; pos_q <= '0; keyed_q <= 1'b0; pad_cnt_q <= '0;
				end
			end
		end
	end

	// Chain value to IV when a key block starts; core applies it before start.
	always_comb begin
		ctl.iv = (state_q == S_KEYLD) && (ld_q == 4'd0);
		ctl.start = (state_q == S_START);
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = (state_q == S_EMIT);
	assign digest_word = chain[emit_q];
	assign word_index = emit_q;
	assign last_word = (emit_q == 3'd4);

	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> emit_q <= 3'd4) else $error("emit index range");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		core_busy |-> in_stall) else $error("accept while core busy");
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(after_q)) else $error("after code");

endmodule

// File: dv/testbench.sv
// Self-checking bench for the HMAC-SHA1 byte-stream engine.
//
// The input side sends message bytes as beats. Each accepted beat goes
// straight into a behavioral HMAC-SHA1 model kept in this module. That model
// holds its own key copy, chain value, block buffer and bit count. When a beat
// marks the end of a message, the model pushes the five expected digest words
// onto a queue.
//
// A monitor compares every accepted output beat with the head of that queue,
// field by field. The test tasks below run in turn:
//   - the reset key,
//   - the extremes of the byte fields,
//   - a key change in the middle of a message,
//   - a long receiver hold-off that backs up the input,
//   - a long random phase with several key settings.
module testbench;
	import hsha_pkg::*;

	localparam logic [31:0] K_R0  = 32'h5a827999;
	localparam logic [31:0] K_R20 = 32'h6ed9eba1;
	localparam logic [31:0] K_R40 = 32'h8f1bbcdc;
	localparam logic [31:0] K_R60 = 32'hca62c1d6;

	// This margin lets the engine finish its work before the bench moves on.
	localparam int SETTLE_CYCLES = 500;
	localparam int RANDOM_ITEMS  = 440;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [KEY_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] data_byte = '0;
	logic byte_present = 1'b0;
	logic last_byte = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [31:0] digest_word;
	logic [2:0] word_index;
	logic last_word;

	hmac_sha1_engine_top DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.data_byte(data_byte), .byte_present(byte_present), .last_byte(last_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.digest_word(digest_word), .word_index(word_index), .last_word(last_word)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// This is the HMAC-SHA1 model's state.
	logic [63:0] key_copy [KEY_REGS];
	logic [31:0] chain [5];
	logic [31:0] block_buf [16];
	logic [31:0] inner_hash [5];
	logic [5:0]  fill_pos;
	logic [63:0] msg_bits;
	bit          msg_open;
	digest_beat_t expected_digest [$];

	int fail_count = 0;
	int beats_sent = 0;
	int messages_done = 0;
	int words_checked = 0;

	// These are the knobs for pacing on both channels.
	bit gaps_on = 1'b1;
	int burst_left = 0;
	int stall_mode = 0;
	int hold_off = 0;

	// One SHA-1 compression of block_buf into the chain value.
	function automatic void sha1_compress();
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, e, f, k, wt, sum;
		w = block_buf;
		a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
		for (int t = 0; t < 80; t++) begin
			if (t >= 16) begin
				wt = w[(t - 3) & 15] ^ w[(t - 8) & 15] ^ w[(t - 14) & 15] ^ w[t & 15];
				wt = {wt[30:0], wt[31]};
				w[t & 15] = wt;
			end else begin
				wt = w[t];
			end
			if (t < 20) begin
				f = d ^ (b & (c ^ d));
				k = K_R0;
			end else if (t < 40) begin
				f = b ^ c ^ d;
				k = K_R20;
			end else if (t < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = K_R40;
			end else begin
				f = b ^ c ^ d;
				k = K_R60;
			end
			sum = {a[26:0], a[31:27]} + f + e + wt + k;
			e = d;
			d = c;
			c = {b[1:0], b[31:2]};
			b = a;
			a = sum;
		end
		chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
	endfunction

	function automatic void hash_key_block(input logic [31:0] pad);
		for (int j = 0; j < 16; j++) begin
			block_buf[j] = ((j & 1) ? key_copy[j / 2][31:0] : key_copy[j / 2][63:32]) ^ pad;
		end
		sha1_compress();
	endfunction

	function automatic void absorb_byte(input logic [7:0] v);
		int sh;
		sh = (3 - fill_pos[1:0]) * 8;
		block_buf[fill_pos[5:2]] = (block_buf[fill_pos[5:2]] & ~(32'hff << sh))
			| ({24'h0, v} << sh);
		fill_pos = fill_pos + 6'd1;
		if (fill_pos == 6'd0) begin
			sha1_compress();
		end
	endfunction

	// This step runs on every accepted input beat.
	function automatic void hmac_step(input logic [7:0] d, input logic p, input logic l);
		logic [63:0] len;
		digest_beat_t beat;
		if (!msg_open) begin
			chain = SHA_IV;
			hash_key_block(IPAD_WORD);
			fill_pos = '0;
			msg_bits = 64'd512;
			msg_open = 1'b1;
		end
		if (p) begin
			msg_bits += 64'd8;
			absorb_byte(d);
		end
		if (l) begin
			len = msg_bits;
			absorb_byte(PAD_BYTE);
			while (fill_pos != 6'd56) begin
				absorb_byte(8'h00);
			end
			for (int i = 0; i < 8; i++) begin
				absorb_byte(len[63 - 8 * i -: 8]);
			end
			inner_hash = chain;
			chain = SHA_IV;
			hash_key_block(OPAD_WORD);
			for (int j = 0; j < 5; j++) begin
				block_buf[j] = inner_hash[j];
			end
			block_buf[5] = {PAD_BYTE, 24'h0};
			for (int j = 6; j < 15; j++) begin
				block_buf[j] = '0;
			end
			block_buf[15] = OUTER_LEN_BITS;
			sha1_compress();
			for (int i = 0; i < DIGEST_WORDS; i++) begin
				beat.word = chain[i];
				beat.index = 3'(i);
				beat.last = (i == DIGEST_WORDS - 1);
				expected_digest.push_back(beat);
			end
			msg_open = 1'b0;
			messages_done++;
		end
	endfunction

	// The receiver stalls on its own pattern. A nonzero hold_off keeps it
	// stalled while hold_off counts down to zero.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_off > 0) begin
			out_stall <= 1'b1;
			hold_off <= hold_off - 1;
		end else begin
			case (stall_mode)
				1: out_stall <= ($urandom_range(0, 2) == 0);
				2: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= 1'b0;
			endcase
		end
	end

	// The monitor checks every output beat that the receiver takes.
	always @(posedge clk) begin
		digest_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_digest.size() == 0) begin
				$error("digest beat with nothing expected: word %h index %0d",
					digest_word, word_index);
				fail_count++;
			end else begin
				want = expected_digest.pop_front();
				words_checked++;
				if (digest_word !== want.word) begin
					$error("digest_word expected %h actual %h", want.word, digest_word);
					fail_count++;
				end
				if (word_index !== want.index) begin
					$error("word_index expected %0d actual %0d", want.index, word_index);
					fail_count++;
				end
				if (last_word !== want.last) begin
					$error("last_word expected %0d actual %0d", want.last, last_word);
					fail_count++;
				end
			end
		end
	end

	// This task sends one beat and waits for the handshake. When a burst runs
	// out and gaps_on is set, valid drops for a random gap.
	task automatic send_beat(input logic [7:0] d, input logic p, input logic l);
		int gap;
		in_valid <= 1'b1;
		data_byte <= d;
		byte_present <= p;
		last_byte <= l;
		do @(posedge clk); while (in_stall);
		hmac_step(d, p, l);
		beats_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 20);
			gap = gaps_on ? $urandom_range(1, 8) : 0;
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic send_message(input int n_bytes);
		for (int i = 0; i < n_bytes; i++) begin
			send_beat(8'($urandom), 1'b1, 1'b0);
		end
		send_beat(8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
	endtask

	// The sender waits for every expected word, then lets the engine settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_digest.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// All eight key registers are written back to back, only while idle.
	task automatic load_key(input logic [63:0] k [KEY_REGS]);
		for (int i = 0; i < KEY_REGS; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= k[i];
			@(posedge clk);
			key_copy[i] = k[i];
		end
		cfg_we <= 1'b0;
	endtask

	// Key shapes: 0 all zero, 1 all ones, 2 full random, 3 short 16-byte key.
	task automatic load_key_shape(input int shape);
		logic [63:0] k [KEY_REGS];
		for (int i = 0; i < KEY_REGS; i++) begin
			case (shape)
				0: k[i] = '0;
				1: k[i] = '1;
				2: k[i] = {$urandom, $urandom};
				default: k[i] = (i < 2) ? {$urandom, $urandom} : 64'h0;
			endcase
		end
		load_key(k);
	endtask

	// With the reset key of all zeros, check the empty message (one last beat
	// with no byte) and a message that opens with an empty beat.
	task automatic test_reset_key();
		send_beat(8'h00, 1'b0, 1'b1);
		send_beat(8'h5a, 1'b0, 1'b0);
		send_beat(8'ha5, 1'b1, 1'b1);
		wait_idle();
	endtask

	// These are field extremes under an all-ones key: bytes 00 and ff,
	// alternating bits, an empty beat inside the message, and a byte on the last
	// beat.
	task automatic test_field_extremes();
		load_key_shape(1);
		send_beat(8'h00, 1'b1, 1'b0);
		send_beat(8'hff, 1'b1, 1'b0);
		send_beat(8'h55, 1'b0, 1'b0);
		send_beat(8'haa, 1'b1, 1'b0);
		send_beat(8'h55, 1'b1, 1'b0);
		send_beat(8'hff, 1'b1, 1'b1);
		send_beat(8'hff, 1'b1, 1'b1);
		wait_idle();
	endtask

	// This case changes the key between the first and last beats. The inner
	// pad keeps the old key and the outer pad uses the new one.
	task automatic test_key_swap_midmessage();
		load_key_shape(2);
		send_beat(8'h12, 1'b1, 1'b0);
		send_beat(8'h34, 1'b1, 1'b0);
		in_valid <= 1'b0;
		repeat (SETTLE_CYCLES) @(posedge clk);
		load_key_shape(3);
		send_beat(8'h56, 1'b1, 1'b1);
		wait_idle();
	endtask

	// The receiver holds off for a long stretch. Meanwhile the next message's
	// beats back up behind the pending digest, so the input must stall.
	task automatic test_output_holdoff();
		gaps_on = 1'b0;
		hold_off = 1500;
		send_message(3);
		send_message(5);
		gaps_on = 1'b1;
		wait_idle();
	endtask

	// Random messages mix short lengths and the padding boundaries. The key
	// and the receiver pattern change every few messages.
	task automatic test_random_messages();
		int start_beats, n, pick;
		int boundary_len [7] = '{55, 56, 57, 63, 64, 119, 120};
		start_beats = beats_sent;
		for (int m = 0; beats_sent - start_beats < RANDOM_ITEMS; m++) begin
			if (m % 6 == 0) begin
				wait_idle();
				load_key_shape((m / 6) % 4);
				stall_mode = (m / 6) % 3;
				gaps_on = ((m / 6) % 2) == 0;
			end
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				n = boundary_len[$urandom_range(0, 6)];
			end else begin
				n = $urandom_range(0, 24);
			end
			for (int i = 0; i < n; i++) begin
				// An empty beat now and then is noise inside the message.
				send_beat(8'($urandom), ($urandom_range(0, 9) != 0), 1'b0);
			end
			send_beat(8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
		end
	endtask

	initial begin
		int waited;
		msg_open = 1'b0;
		fill_pos = '0;
		msg_bits = '0;
		for (int i = 0; i < KEY_REGS; i++) begin
			key_copy[i] = '0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_key();
		test_field_extremes();
		test_key_swap_midmessage();
		test_output_holdoff();
		test_random_messages();

		// Drain the last digests. The wait is bounded so that a hang still ends
		// the run.
		in_valid <= 1'b0;
		stall_mode = 1;
		waited = 0;
		while (expected_digest.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		if (expected_digest.size() != 0) begin
			$error("%0d digest words never arrived", expected_digest.size());
			fail_count++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d input beats over %0d messages and checked %0d digest words,",
			beats_sent, messages_done, words_checked);
		$display("with zero, all-ones, random and short keys plus a mid-message key change.");
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// This is a backstop in case the engine hangs somewhere.
	initial begin
		#6000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
